// ===== hw/rtl/bbe_pkg.sv =====
// Package for the byte block entropy unit: widths, FSM command struct and the
// log2 fraction table function. No dependencies.
package bbe_pkg;

    localparam int MaxBlockDefault = 4096;
    localparam int LogTableBitsDefault = 8;
    localparam int Bins = 256;
    localparam int CntWidth = 17;          // holds MAX_BLOCK up to 65536
    localparam int LogWidth = 21;          // log2 in Q16, exponent up to 16
    localparam int AccWidth = 40;          // sum of c*log2(c)
    localparam int OutWidth = 16;
    localparam int CountOutWidth = 13;

    // Controller to datapath commands.
    typedef struct packed {
        logic       clr_sweep;   // write zero at the sweep address
        logic       rd_issue;    // read histogram at the sweep address
        logic       acc_en;      // accumulate the product of the word read
        logic       start_tot;   // form N*log2(N) and start the divider
        logic       clr_stats;   // clear length counter, flag and accumulator
    } bbe_cmd_t;

    typedef struct packed {
        logic       div_done;
    } bbe_sts_t;

    // log2(1 + i/2^bits) in Q16, built by repeated squaring, truncated.
    function automatic logic [16:0] log_frac(input int i, input int bits);
        logic [63:0] y;
        logic [16:0] acc;
        if (i >= (1 << bits)) begin
            log_frac = 17'd65536;
        end else begin
            y = 64'((1 << bits) + i) << (30 - bits);
            acc = '0;
            for (int k = 0; k < 16; k++) begin
                y = (y * y) >> 30;
                acc = acc << 1;
                if (y >= 64'h8000_0000) begin
                    acc[0] = 1'b1;
                    y = y >> 1;
                end
            end
            log_frac = acc;
        end
    endfunction

endpackage

// ===== hw/rtl/bbe_ram.sv =====
// Generic single-port write, single-port read RAM with a registered read.
// No dependencies.
module bbe_ram #(
    parameter int Width = 8,
    parameter int Depth = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(Depth)-1:0] waddr,
    input  logic [Width-1:0]         wdata,
    input  logic [$clog2(Depth)-1:0] raddr,
    output logic [Width-1:0]         rdata
);
    logic [Width-1:0] mem [Depth];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ===== hw/rtl/bbe_log2.sv =====
// Pipelined log2 in Q16 with table interpolation (three register stages).
// Depends on bbe_pkg.
module bbe_log2 #(
    parameter int LogTableBits = bbe_pkg::LogTableBitsDefault
) (
    input  logic                          aclk,
    input  logic [bbe_pkg::CntWidth-1:0]  x,
    output logic [bbe_pkg::LogWidth-1:0]  y
);
    localparam int TabSize = (1 << LogTableBits) + 1;
    localparam int InterpBits = 16 - LogTableBits;
    localparam int EW = 5;

    logic [16:0] tab [TabSize];
    always_comb begin
        for (int i = 0; i < TabSize; i++) begin
            tab[i] = bbe_pkg::log_frac(i, LogTableBits);
        end
    end

    logic [EW-1:0] e_next, e_reg, e2_reg;
    logic [15:0]   f_next, f_reg;
    logic [16:0]   lo_reg, dif_reg;
    logic [InterpBits-1:0] r_reg;
    logic [bbe_pkg::LogWidth-1:0] y_reg;
    logic [LogTableBits-1:0] idx;

    always_comb begin
        e_next = '0;
        for (int b = 1; b < bbe_pkg::CntWidth; b++) begin
            if (x[b]) e_next = EW'(b);
        end
        f_next = 16'((33'(x) << (16 - e_next)) >> 0);
        if (e_next > 5'd16) f_next = 16'(x >> (e_next - 5'd16));
    end

    assign idx = f_reg[15 -: LogTableBits];

    always_ff @(posedge aclk) begin
        e_reg   <= e_next;
        f_reg   <= f_next;
        e2_reg  <= e_reg;
        lo_reg  <= tab[idx];
        dif_reg <= tab[32'(idx) + 1] - tab[idx];
        r_reg   <= f_reg[InterpBits-1:0];
        y_reg   <= bbe_pkg::LogWidth'({e2_reg, 16'd0}) + bbe_pkg::LogWidth'(lo_reg)
                 + bbe_pkg::LogWidth'((26'(dif_reg) * 26'(r_reg)) >> InterpBits);
    end
    assign y = y_reg;
endmodule

// ===== hw/rtl/bbe_ctrl.sv =====
// Controller FSM: counting, end-of-block histogram pass, divide, result,
// clearing. Depends on bbe_pkg.
module bbe_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_fire,
    input  logic              in_last,
    input  logic              out_free,
    input  bbe_pkg::bbe_sts_t sts,
    output bbe_pkg::bbe_cmd_t cmd,
    output logic [7:0]        addr,
    output logic              in_ready,
    output logic              res_load
);
    typedef enum logic [2:0] {
        ST_CLEAR, ST_COUNT, ST_SETTLE, ST_SCAN, ST_DRAIN, ST_DIV, ST_OUT
    } state_t;

    state_t     state_reg;
    logic [7:0] addr_reg;
    logic [3:0] drain_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
            addr_reg  <= '0;
            drain_reg <= '0;
        end else begin
            case (state_reg)
                ST_CLEAR: begin
                    addr_reg <= addr_reg + 8'd1;
                    if (addr_reg == 8'hFF) state_reg <= ST_COUNT;
                end
                ST_COUNT: begin
                    if (in_fire && in_last) begin
                        state_reg <= ST_SETTLE;
                    end
                end
                // The last byte's bin write lands here, before the scan
                // reads the first bin.
                ST_SETTLE: begin
                    state_reg <= ST_SCAN;
                    addr_reg  <= '0;
                end
                ST_SCAN: begin
                    addr_reg <= addr_reg + 8'd1;
                    if (addr_reg == 8'hFF) begin
                        state_reg <= ST_DRAIN;
                        drain_reg <= '0;
                    end
                end
                ST_DRAIN: begin
                    drain_reg <= drain_reg + 4'd1;
                    if (drain_reg == 4'd7) state_reg <= ST_DIV;
                end
                ST_DIV: begin
                    if (sts.div_done) state_reg <= ST_OUT;
                end
                ST_OUT: begin
                    if (out_free) begin
                        state_reg <= ST_CLEAR;
                        addr_reg  <= '0;
                    end
                end
                default: state_reg <= ST_CLEAR;
            endcase
        end
    end

    // The scan and the clearing sweep run at different times, so they share
    // the address counter.
    always_comb begin
        cmd = '0;
        cmd.clr_sweep = (state_reg == ST_CLEAR);
        cmd.rd_issue  = (state_reg == ST_SCAN);
        cmd.acc_en    = (state_reg == ST_SCAN) || (state_reg == ST_DRAIN);
        cmd.start_tot = (state_reg == ST_DRAIN) && (drain_reg == 4'd7);
        cmd.clr_stats = (state_reg == ST_OUT) && out_free;
    end

    assign addr     = addr_reg;
    assign in_ready = (state_reg == ST_COUNT);
    assign res_load = (state_reg == ST_OUT) && out_free;
endmodule

// ===== hw/rtl/bbe_dp.sv =====
// Datapath: histogram RAM with read-modify-write, log2 pipeline, product
// accumulator and a restoring divider. Depends on bbe_pkg, bbe_ram, bbe_log2.
module bbe_dp #(
    parameter int MaxBlock = bbe_pkg::MaxBlockDefault,
    parameter int LogTableBits = bbe_pkg::LogTableBitsDefault
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  bbe_pkg::bbe_cmd_t cmd,
    input  logic [7:0]        addr,
    input  logic              in_fire,
    input  logic [7:0]        in_byte,
    output bbe_pkg::bbe_sts_t sts,
    output logic [15:0]       entropy,
    output logic [12:0]       count,
    output logic              too_long
);
    localparam int CW = bbe_pkg::CntWidth;
    localparam int AW = bbe_pkg::AccWidth;
    localparam int LW = bbe_pkg::LogWidth;
    localparam int DivW = AW;

    // Counting: a byte's bin is read, then written in the next cycle. A bypass
    // handles a repeat of the same byte in back-to-back cycles.
    logic          cnt_ok;
    logic          wr_pend_reg;
    logic [7:0]    wr_addr_reg;
    logic [CW-1:0] ram_rdata, bin_val, wr_data;
    logic [CW-1:0] last_wr_reg;
    logic          last_wv_reg;
    logic [7:0]    last_wa_reg;
    logic [CW-1:0] len_reg;
    logic          ovf_reg;
    logic          ram_we;
    logic [7:0]    ram_waddr, ram_raddr;
    logic [CW-1:0] ram_wdata;

    assign cnt_ok = in_fire && (len_reg < CW'(MaxBlock));
    assign bin_val = (last_wv_reg && last_wa_reg == wr_addr_reg) ? last_wr_reg : ram_rdata;
    assign wr_data = bin_val + CW'(1);

    always_comb begin
        ram_we    = wr_pend_reg || cmd.clr_sweep;
        ram_waddr = cmd.clr_sweep ? addr : wr_addr_reg;
        ram_wdata = cmd.clr_sweep ? '0 : wr_data;
        ram_raddr = cmd.rd_issue ? addr : in_byte;
    end

    bbe_ram #(.Width(CW), .Depth(bbe_pkg::Bins)) u_hist (
        .aclk(aclk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
        .raddr(ram_raddr), .rdata(ram_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_pend_reg <= 1'b0;
            last_wv_reg <= 1'b0;
            len_reg     <= '0;
            ovf_reg     <= 1'b0;
        end else begin
            wr_pend_reg <= cnt_ok;
            last_wv_reg <= wr_pend_reg;
            if (cnt_ok) len_reg <= len_reg + CW'(1);
            else if (in_fire) ovf_reg <= 1'b1;
            if (cmd.clr_stats) begin
                len_reg <= '0;
                ovf_reg <= 1'b0;
            end
        end
        wr_addr_reg <= in_byte;
        last_wa_reg <= wr_addr_reg;
        last_wr_reg <= wr_data;
    end

    // Scan: RAM read (1) -> log2 (3) -> product (1) -> accumulate.
    logic          v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic [CW-1:0] c1_reg, c2_reg, c3_reg;
    logic [LW-1:0] lg;
    logic [AW-1:0] prod_reg, sum_reg;
    logic [CW-1:0] log_in;
    logic          tot_sel_reg;

    assign log_in = tot_sel_reg ? len_reg : ram_rdata;

    bbe_log2 #(.LogTableBits(LogTableBits)) u_log (.aclk(aclk), .x(log_in), .y(lg));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0; v2_reg <= 1'b0; v3_reg <= 1'b0;
            v4_reg <= 1'b0; v5_reg <= 1'b0;
            sum_reg <= '0;
            tot_sel_reg <= 1'b0;
        end else begin
            v1_reg <= cmd.rd_issue;
            v2_reg <= v1_reg; v3_reg <= v2_reg; v4_reg <= v3_reg; v5_reg <= v4_reg;
            if (v5_reg && cmd.acc_en) sum_reg <= sum_reg + prod_reg;
            if (cmd.clr_stats) sum_reg <= '0;
            tot_sel_reg <= cmd.acc_en && !v1_reg && !cmd.rd_issue;
        end
        c1_reg <= ram_rdata;
        c2_reg <= c1_reg; c3_reg <= c2_reg;
        prod_reg <= AW'(c3_reg) * AW'(lg);
    end

    // N*log2(N): after the drain, the log pipeline output reflects len_reg.
    // Divider: restoring, one quotient bit a cycle, (num + 8n) / (16n).
    logic [DivW-1:0] rem_reg, quo_reg, den_reg;
    logic [5:0]      dcnt_reg;
    logic            busy_reg, done_reg;
    logic [AW-1:0]   tot;
    logic [AW-1:0]   diff;
    logic [DivW:0]   trial;

    assign tot  = AW'(len_reg) * AW'(lg);
    assign diff = (tot > sum_reg) ? tot - sum_reg : '0;
    assign trial = {rem_reg, quo_reg[DivW-1]} - {1'b0, den_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            dcnt_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (cmd.start_tot) begin
                busy_reg <= (len_reg != '0);
                done_reg <= (len_reg == '0);
                quo_reg  <= diff + (AW'(len_reg) << 3);
                rem_reg  <= '0;
                den_reg  <= AW'(len_reg) << 4;
                dcnt_reg <= '0;
            end else if (busy_reg) begin
                if (!trial[DivW]) begin
                    rem_reg <= trial[DivW-1:0];
                    quo_reg <= {quo_reg[DivW-2:0], 1'b1};
                end else begin
                    rem_reg <= {rem_reg[DivW-2:0], quo_reg[DivW-1]};
                    quo_reg <= {quo_reg[DivW-2:0], 1'b0};
                end
                dcnt_reg <= dcnt_reg + 6'd1;
                if (dcnt_reg == 6'(DivW - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // len_reg == 0 is impossible at the end (last byte counts or max reached),
    // but a zero quotient is kept when the divider is skipped.
    logic [15:0] ent_reg;
    always_ff @(posedge aclk) begin
        if (done_reg) begin
            if (len_reg == '0) ent_reg <= '0;
            else if (quo_reg > DivW'(32768)) ent_reg <= 16'd32768;
            else ent_reg <= quo_reg[15:0];
        end
    end

    assign sts.div_done = done_reg;
    assign entropy  = ent_reg;
    assign count    = len_reg[12:0];
    assign too_long = ovf_reg;
endmodule

// ===== hw/rtl/byte_block_entropy_unit.sv =====
// Byte block entropy unit: one byte transfer per cycle while a block streams in.
// m_tvalid rises after the last byte's transfer once a settle state, a scan of all
// 256 histogram bins, a pipeline drain, the divide and the result load have run.
// A sweep of all 256 bins then clears the histogram; s_tready returns after it
// if the result register is free, later while a result waits in it.
// After reset the same sweep runs with s_tready low. Reset is synchronous, active low.
module byte_block_entropy_unit #(
    parameter int MAX_BLOCK = bbe_pkg::MaxBlockDefault,
    parameter int LOG_TABLE_BITS = bbe_pkg::LogTableBitsDefault
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tlast,   // last_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [15:0] entropy_q12, [28:16] byte_count,
                                   // [29] too_long, [31:30] zero
    output logic        m_tlast
);
    bbe_pkg::bbe_cmd_t cmd;
    bbe_pkg::bbe_sts_t sts;
    logic [7:0]  addr;
    logic        in_ready, in_fire, res_load, out_free;
    logic [15:0] entropy;
    logic [12:0] count;
    logic        too_long;
    logic        mv_reg;
    logic [31:0] md_reg;

    assign in_fire  = s_tvalid && in_ready;
    // The result register frees when empty or being taken this cycle.
    assign out_free = !mv_reg || m_tready;

    bbe_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .in_fire(in_fire), .in_last(s_tlast),
        .out_free(out_free), .sts(sts), .cmd(cmd), .addr(addr),
        .in_ready(in_ready), .res_load(res_load)
    );

    bbe_dp #(.MaxBlock(MAX_BLOCK), .LogTableBits(LOG_TABLE_BITS)) u_dp (
        .aclk(aclk), .aresetn(aresetn), .cmd(cmd), .addr(addr),
        .in_fire(in_fire), .in_byte(s_tdata), .sts(sts),
        .entropy(entropy), .count(count), .too_long(too_long)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mv_reg <= 1'b0;
        end else begin
            if (res_load) mv_reg <= 1'b1;
            else if (m_tready) mv_reg <= 1'b0;
        end
        if (res_load) md_reg <= {2'b00, too_long, count, entropy};
    end

    assign s_tready = in_ready;
    assign m_tvalid = mv_reg;
    assign m_tdata  = md_reg;
    assign m_tlast  = 1'b1;
endmodule

// ===== hw/rtl/bbe_checker.sv =====
// Port-level checker for the byte block entropy unit, bound to the top level.
// Depends on byte_block_entropy_unit.
module bbe_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        s_tlast,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata
);
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)) else $error("result dropped");
    a_last: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tlast |=> !s_tready) else $error("input open after last");
    a_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[15:0] <= 16'd32768) else $error("entropy out of range");
    a_cnt: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[28:16] != 13'd0 || m_tdata[15:0] == 16'd0)
        else $error("entropy with no bytes");
endmodule

bind byte_block_entropy_unit bbe_checker u_bbe_checker (
    .aclk(aclk), .aresetn(aresetn), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .s_tlast(s_tlast), .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);
